>>> hdl/prd_pkg.sv
// Shared widths and register indexes for the pixel ray direction block.
`default_nettype none
package prd_pkg;

   // field widths
   localparam int COORD_BITS  = 12;
   localparam int FRAC_BITS   = 16;
   localparam int SIZE_BITS   = 13;
   localparam int HALF_BITS   = SIZE_BITS - 1;
   localparam int TAN_BITS    = FRAC_BITS + 4;
   localparam int XY_OUT_BITS = FRAC_BITS + 2;
   localparam int Z_OUT_BITS  = FRAC_BITS + 1;

   // scaled tangent: tan * |delta|, then round(num / half)
   localparam int NUM_BITS    = TAN_BITS + COORD_BITS;
   localparam int DVD_BITS    = NUM_BITS + 2;
   localparam int SREM_BITS   = SIZE_BITS;

   // normalisation
   localparam int MAG_BITS    = 30;
   localparam int SUM_BITS    = 2 * MAG_BITS + 2;
   localparam int ROOT_BITS   = SUM_BITS / 2;
   localparam int RREM_BITS   = ROOT_BITS + 1;
   localparam int ND_BITS     = MAG_BITS + FRAC_BITS + 1;
   localparam int Q_BITS      = FRAC_BITS + 1;
   localparam int LANES       = 3;

   // configuration port
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = TAN_BITS;
   localparam logic [CSR_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_TAN_X        = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_TAN_Y        = 3'd3;

   localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = 13'd480;
   localparam logic [TAN_BITS-1:0]  TAN_RESET    = 20'd37837;

endpackage
`default_nettype wire

>>> hdl/prd_scale.sv
// Scaled tangent per axis: tan * |delta| then rounded division by the half size.
`default_nettype none
module prd_scale (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              adv,
   input  wire logic                              in_valid,
   input  wire logic [prd_pkg::COORD_BITS-1:0]    px,
   input  wire logic [prd_pkg::COORD_BITS-1:0]    py,
   input  wire logic [prd_pkg::HALF_BITS-1:0]     hw,
   input  wire logic [prd_pkg::HALF_BITS-1:0]     hh,
   input  wire logic [prd_pkg::TAN_BITS-1:0]      tan_x,
   input  wire logic [prd_pkg::TAN_BITS-1:0]      tan_y,
   output logic                                   out_valid,
   output logic [prd_pkg::NUM_BITS-1:0]           mag_a,
   output logic [prd_pkg::NUM_BITS-1:0]           mag_b,
   output logic                                   neg_a,
   output logic                                   neg_b
);

   localparam int N = prd_pkg::DVD_BITS;

   logic [prd_pkg::COORD_BITS-1:0] dmag_c [0:1];
   logic                           dneg_c [0:1];
   logic [prd_pkg::HALF_BITS-1:0]  half_c [0:1];

   logic [prd_pkg::NUM_BITS-1:0]   num_ff [0:1];
   logic                           nneg_ff [0:1];
   logic                           nvld_ff;

   logic [prd_pkg::DVD_BITS-1:0]   dvd_ff [0:1][1:N];
   logic [prd_pkg::SREM_BITS-1:0]  rem_ff [0:1][1:N];
   logic                           neg_ff [0:1][1:N];
   logic                           vld_ff [1:N];

   logic [prd_pkg::DVD_BITS-1:0]   dvd_cur [0:1][0:N-1];
   logic [prd_pkg::SREM_BITS-1:0]  rem_cur [0:1][0:N-1];
   logic                           neg_cur [0:1][0:N-1];
   logic [prd_pkg::DVD_BITS-1:0]   dvd_in  [0:1][0:N-1];
   logic [prd_pkg::SREM_BITS-1:0]  rem_in  [0:1][0:N-1];

   // signed offsets from the centre, split into sign and magnitude
   always_comb begin
      half_c[0] = hw;
      half_c[1] = hh;
      dneg_c[0] = px < hw;
      dmag_c[0] = dneg_c[0] ? (hw - px) : (px - hw);
      dneg_c[1] = py > hh;
      dmag_c[1] = dneg_c[1] ? (py - hh) : (hh - py);
   end

   // product stage
   always_ff @(posedge clock) begin
      if (adv) begin
         num_ff[0]  <= prd_pkg::NUM_BITS'(tan_x) * prd_pkg::NUM_BITS'(dmag_c[0]);
         num_ff[1]  <= prd_pkg::NUM_BITS'(tan_y) * prd_pkg::NUM_BITS'(dmag_c[1]);
         nneg_ff[0] <= dneg_c[0];
         nneg_ff[1] <= dneg_c[1];
      end
   end

   // restoring divide of (2*num + half) by 2*half, one quotient bit per stage
   always_comb begin
      logic [prd_pkg::SREM_BITS:0]   t;
      logic [prd_pkg::SREM_BITS-1:0] dv;
      for (int l = 0; l < 2; l++) begin
         dv = {half_c[l], 1'b0};
         dvd_cur[l][0] = {num_ff[l], 1'b0} + prd_pkg::DVD_BITS'(half_c[l]);
         rem_cur[l][0] = '0;
         neg_cur[l][0] = nneg_ff[l];
         for (int k = 1; k < N; k++) begin
            dvd_cur[l][k] = dvd_ff[l][k];
            rem_cur[l][k] = rem_ff[l][k];
            neg_cur[l][k] = neg_ff[l][k];
         end
         for (int k = 0; k < N; k++) begin
            t = {rem_cur[l][k], dvd_cur[l][k][N-1]};
            if (t >= {1'b0, dv}) begin
               rem_in[l][k] = prd_pkg::SREM_BITS'(t - {1'b0, dv});
               dvd_in[l][k] = {dvd_cur[l][k][N-2:0], 1'b1};
            end else begin
               rem_in[l][k] = t[prd_pkg::SREM_BITS-1:0];
               dvd_in[l][k] = {dvd_cur[l][k][N-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < 2; l++) begin
            for (int k = 0; k < N; k++) begin
               dvd_ff[l][k+1] <= dvd_in[l][k];
               rem_ff[l][k+1] <= rem_in[l][k];
               neg_ff[l][k+1] <= neg_cur[l][k];
            end
         end
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         nvld_ff <= 1'b0;
         for (int k = 1; k <= N; k++) vld_ff[k] <= 1'b0;
      end else if (adv) begin
         nvld_ff  <= in_valid;
         vld_ff[1] <= nvld_ff;
         for (int k = 2; k <= N; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   assign out_valid = vld_ff[N];
   assign mag_a     = dvd_ff[0][N][prd_pkg::NUM_BITS-1:0];
   assign mag_b     = dvd_ff[1][N][prd_pkg::NUM_BITS-1:0];
   assign neg_a     = neg_ff[0][N];
   assign neg_b     = neg_ff[1][N];

endmodule
`default_nettype wire

>>> hdl/prd_norm.sv
// Normalisation: pipelined square root and per-lane rounded division by the root.
`default_nettype none
module prd_norm (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          adv,
   input  wire logic                          in_valid,
   input  wire logic [prd_pkg::SUM_BITS-1:0]  sum,
   input  wire logic [prd_pkg::MAG_BITS-1:0]  mag [0:prd_pkg::LANES-1],
   output logic                               out_valid,
   output logic [prd_pkg::Q_BITS-1:0]         quo [0:prd_pkg::LANES-1]
);

   localparam int NS = prd_pkg::ROOT_BITS;
   localparam int NQ = prd_pkg::Q_BITS;
   localparam int L  = prd_pkg::LANES;

   // square root stages
   logic [prd_pkg::SUM_BITS-1:0]  src_ff  [1:NS];
   logic [prd_pkg::RREM_BITS-1:0] srem_ff [1:NS];
   logic [prd_pkg::ROOT_BITS-1:0] root_ff [1:NS];
   logic [prd_pkg::MAG_BITS-1:0]  smag_ff [0:L-1][1:NS];
   logic                          svld_ff [1:NS];

   logic [prd_pkg::SUM_BITS-1:0]  src_cur  [0:NS-1];
   logic [prd_pkg::RREM_BITS-1:0] srem_cur [0:NS-1];
   logic [prd_pkg::ROOT_BITS-1:0] root_cur [0:NS-1];
   logic [prd_pkg::RREM_BITS-1:0] srem_in  [0:NS-1];
   logic [prd_pkg::ROOT_BITS-1:0] root_in  [0:NS-1];

   // dividend set-up stage
   logic [prd_pkg::ND_BITS-1:0]   nd_ff [0:L-1];
   logic [prd_pkg::ROOT_BITS-1:0] r_ff;
   logic                          nvld_ff;

   // division stages
   logic [prd_pkg::Q_BITS-1:0]    dvd_ff [0:L-1][1:NQ];
   logic [prd_pkg::ROOT_BITS-1:0] rem_ff [0:L-1][1:NQ];
   logic [prd_pkg::ROOT_BITS-1:0] dr_ff  [1:NQ];
   logic                          vld_ff [1:NQ];

   logic [prd_pkg::Q_BITS-1:0]    dvd_cur [0:L-1][0:NQ-1];
   logic [prd_pkg::ROOT_BITS-1:0] rem_cur [0:L-1][0:NQ-1];
   logic [prd_pkg::ROOT_BITS-1:0] dr_cur  [0:NQ-1];
   logic [prd_pkg::Q_BITS-1:0]    dvd_in  [0:L-1][0:NQ-1];
   logic [prd_pkg::ROOT_BITS-1:0] rem_in  [0:L-1][0:NQ-1];

   // digit-by-digit square root, one root bit per stage
   always_comb begin
      logic [prd_pkg::RREM_BITS+1:0] t;
      logic [prd_pkg::RREM_BITS+1:0] trial;
      src_cur[0]  = sum;
      srem_cur[0] = '0;
      root_cur[0] = '0;
      for (int k = 1; k < NS; k++) begin
         src_cur[k]  = src_ff[k];
         srem_cur[k] = srem_ff[k];
         root_cur[k] = root_ff[k];
      end
      for (int k = 0; k < NS; k++) begin
         t     = {srem_cur[k], src_cur[k][prd_pkg::SUM_BITS-1 -: 2]};
         trial = (prd_pkg::RREM_BITS+2)'({root_cur[k], 2'b01});
         if (t >= trial) begin
            srem_in[k] = prd_pkg::RREM_BITS'(t - trial);
            root_in[k] = {root_cur[k][prd_pkg::ROOT_BITS-2:0], 1'b1};
         end else begin
            srem_in[k] = t[prd_pkg::RREM_BITS-1:0];
            root_in[k] = {root_cur[k][prd_pkg::ROOT_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NS; k++) begin
            src_ff[k+1]  <= {src_cur[k][prd_pkg::SUM_BITS-3:0], 2'b00};
            srem_ff[k+1] <= srem_in[k];
            root_ff[k+1] <= root_in[k];
         end
         for (int l = 0; l < L; l++) begin
            smag_ff[l][1] <= mag[l];
            for (int k = 2; k <= NS; k++) smag_ff[l][k] <= smag_ff[l][k-1];
         end
      end
   end

   // dividend = mag * 2^FRAC + r/2
   always_ff @(posedge clock) begin
      if (adv) begin
         r_ff <= root_ff[NS];
         for (int l = 0; l < L; l++) begin
            nd_ff[l] <= prd_pkg::ND_BITS'({smag_ff[l][NS], {prd_pkg::FRAC_BITS{1'b0}}})
                      + prd_pkg::ND_BITS'(root_ff[NS] >> 1);
         end
      end
   end

   // restoring divide by r; the quotient never exceeds 2^FRAC, so the
   // upper dividend bits seed the remainder directly
   always_comb begin
      logic [prd_pkg::ROOT_BITS:0] t;
      dr_cur[0] = r_ff;
      for (int k = 1; k < NQ; k++) dr_cur[k] = dr_ff[k];
      for (int l = 0; l < L; l++) begin
         dvd_cur[l][0] = nd_ff[l][NQ-1:0];
         rem_cur[l][0] = prd_pkg::ROOT_BITS'(nd_ff[l][prd_pkg::ND_BITS-1:NQ]);
         for (int k = 1; k < NQ; k++) begin
            dvd_cur[l][k] = dvd_ff[l][k];
            rem_cur[l][k] = rem_ff[l][k];
         end
         for (int k = 0; k < NQ; k++) begin
            t = {rem_cur[l][k], dvd_cur[l][k][NQ-1]};
            if (t >= {1'b0, dr_cur[k]}) begin
               rem_in[l][k] = prd_pkg::ROOT_BITS'(t - {1'b0, dr_cur[k]});
               dvd_in[l][k] = {dvd_cur[l][k][NQ-2:0], 1'b1};
            end else begin
               rem_in[l][k] = t[prd_pkg::ROOT_BITS-1:0];
               dvd_in[l][k] = {dvd_cur[l][k][NQ-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NQ; k++) begin
            dr_ff[k+1] <= dr_cur[k];
            for (int l = 0; l < L; l++) begin
               dvd_ff[l][k+1] <= dvd_in[l][k];
               rem_ff[l][k+1] <= rem_in[l][k];
            end
         end
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= NS; k++) svld_ff[k] <= 1'b0;
         nvld_ff <= 1'b0;
         for (int k = 1; k <= NQ; k++) vld_ff[k] <= 1'b0;
      end else if (adv) begin
         svld_ff[1] <= in_valid;
         for (int k = 2; k <= NS; k++) svld_ff[k] <= svld_ff[k-1];
         nvld_ff   <= svld_ff[NS];
         vld_ff[1] <= nvld_ff;
         for (int k = 2; k <= NQ; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   assign out_valid = vld_ff[NQ];
   always_comb begin
      for (int l = 0; l < L; l++) quo[l] = dvd_ff[l][NQ];
   end

endmodule
`default_nettype wire

>>> hdl/pixel_ray_direction_top.sv
// Top level of the pinhole camera primary ray direction pipeline.
//
// Usage: pixel coordinates enter on the req_ stream (pixel_x, pixel_y) and one
// unit ray direction per item leaves on the rsp_ stream as signed Q1.16
// components (dir_x, dir_y, dir_z). Frame size and tan(fov/2) per axis are
// written through the csr_ channel, which is ready whenever reset is low;
// write only while the pipeline holds no item.
// Throughput: one item per cycle while rsp_ does not stall. The result reaches
// rsp_ through 89 register stages: input register, product, 34 stages of the
// half-size divider, scale shift, squares, sum, 31 square root stages,
// dividend set-up, 17 stages of the normalising divider and the output
// register. The two dividers and the root settle one bit per stage.
// Stall: the whole pipeline holds while a result waits on rsp_ without
// rsp_tready; req_tready drops for that time and nothing is lost or repeated.
// Reset: req_tready and csr_ready stay low, all valid bits clear and the
// registers return to 640x480 with both tangents at 37837 (about 0.577).
`default_nettype none
module pixel_ray_direction_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // req_tdata: pixel_x [11:0], pixel_y [23:12]
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [23:0]                        req_tdata,
   // rsp_tdata: dir_x [17:0], dir_y [35:18], dir_z [52:36], zero [55:53]
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [55:0]                             rsp_tdata,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [prd_pkg::CSR_IDX_BITS-1:0]   csr_addr,
   input  wire logic [prd_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int L = prd_pkg::LANES;

   logic                           adv;
   logic [prd_pkg::SIZE_BITS-1:0]  width_ff, height_ff;
   logic [prd_pkg::TAN_BITS-1:0]   tanx_ff, tany_ff;
   logic [prd_pkg::HALF_BITS-1:0]  hw, hh;

   logic                           ivld_ff;
   logic [prd_pkg::COORD_BITS-1:0] px_ff, py_ff;

   logic                           sc_valid;
   logic [prd_pkg::NUM_BITS-1:0]   sc_a, sc_b;
   logic                           sc_neg_a, sc_neg_b;
   logic                           shift1, shift2;

   logic                           shvld_ff, sqvld_ff, smvld_ff;
   logic [prd_pkg::MAG_BITS-1:0]   sh_ff [0:L-1];
   logic [prd_pkg::MAG_BITS-1:0]   sqm_ff [0:L-1];
   logic [prd_pkg::MAG_BITS-1:0]   smm_ff [0:L-1];
   logic [2*prd_pkg::MAG_BITS-1:0] sq_ff [0:L-1];
   logic [prd_pkg::SUM_BITS-1:0]   sum_ff;
   logic [prd_pkg::MAG_BITS-1:0]   sh_in [0:L-1];

   // signs ride alongside the normalisation in a matching delay line
   localparam int NDLY = prd_pkg::ROOT_BITS + prd_pkg::Q_BITS + 1 + 3;
   logic                           nega_ff [1:NDLY];
   logic                           negb_ff [1:NDLY];

   logic                           nm_valid;
   logic [prd_pkg::Q_BITS-1:0]     nm_q [0:L-1];

   logic                           ovld_ff;
   logic [prd_pkg::XY_OUT_BITS-1:0] dirx_ff, diry_ff;
   logic [prd_pkg::Z_OUT_BITS-1:0]  dirz_ff;

   // whole pipeline moves when the output register is free or being taken
   assign adv        = !ovld_ff || rsp_tready;
   assign req_tready = adv && !reset;
   assign csr_ready  = !reset;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= prd_pkg::WIDTH_RESET;
         height_ff <= prd_pkg::HEIGHT_RESET;
         tanx_ff   <= prd_pkg::TAN_RESET;
         tany_ff   <= prd_pkg::TAN_RESET;
      end else if (csr_valid) begin
         case (csr_addr)
            prd_pkg::REG_IMAGE_WIDTH:  width_ff  <= csr_wdata[prd_pkg::SIZE_BITS-1:0];
            prd_pkg::REG_IMAGE_HEIGHT: height_ff <= csr_wdata[prd_pkg::SIZE_BITS-1:0];
            prd_pkg::REG_TAN_X:        tanx_ff   <= csr_wdata;
            prd_pkg::REG_TAN_Y:        tany_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // half sizes, a zero half is taken as one
   always_comb begin
      hw = width_ff[prd_pkg::SIZE_BITS-1:1];
      hh = height_ff[prd_pkg::SIZE_BITS-1:1];
      if (hw == '0) hw = prd_pkg::HALF_BITS'(1);
      if (hh == '0) hh = prd_pkg::HALF_BITS'(1);
   end

   // input register
   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff <= req_tdata[prd_pkg::COORD_BITS-1:0];
         py_ff <= req_tdata[2*prd_pkg::COORD_BITS-1:prd_pkg::COORD_BITS];
      end
   end

   prd_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (ivld_ff),
      .px        (px_ff),
      .py        (py_ff),
      .hw        (hw),
      .hh        (hh),
      .tan_x     (tanx_ff),
      .tan_y     (tany_ff),
      .out_valid (sc_valid),
      .mag_a     (sc_a),
      .mag_b     (sc_b),
      .neg_a     (sc_neg_a),
      .neg_b     (sc_neg_b)
   );

   // bring the largest magnitude below 2^30
   always_comb begin
      shift2 = sc_a[prd_pkg::NUM_BITS-1] | sc_b[prd_pkg::NUM_BITS-1];
      shift1 = sc_a[prd_pkg::NUM_BITS-2] | sc_b[prd_pkg::NUM_BITS-2];
      if (shift2) begin
         sh_in[0] = sc_a[prd_pkg::NUM_BITS-1:2];
         sh_in[1] = sc_b[prd_pkg::NUM_BITS-1:2];
         sh_in[2] = prd_pkg::MAG_BITS'(1) << (prd_pkg::FRAC_BITS - 2);
      end else if (shift1) begin
         sh_in[0] = sc_a[prd_pkg::NUM_BITS-2:1];
         sh_in[1] = sc_b[prd_pkg::NUM_BITS-2:1];
         sh_in[2] = prd_pkg::MAG_BITS'(1) << (prd_pkg::FRAC_BITS - 1);
      end else begin
         sh_in[0] = sc_a[prd_pkg::MAG_BITS-1:0];
         sh_in[1] = sc_b[prd_pkg::MAG_BITS-1:0];
         sh_in[2] = prd_pkg::MAG_BITS'(1) << prd_pkg::FRAC_BITS;
      end
   end

   // shift, square and sum stages
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < L; l++) begin
            sh_ff[l]  <= sh_in[l];
            sqm_ff[l] <= sh_ff[l];
            sq_ff[l]  <= (2*prd_pkg::MAG_BITS)'(sh_ff[l]) * (2*prd_pkg::MAG_BITS)'(sh_ff[l]);
            smm_ff[l] <= sqm_ff[l];
         end
         sum_ff <= prd_pkg::SUM_BITS'(sq_ff[0]) + prd_pkg::SUM_BITS'(sq_ff[1])
                 + prd_pkg::SUM_BITS'(sq_ff[2]);
         nega_ff[1] <= sc_neg_a;
         negb_ff[1] <= sc_neg_b;
         for (int k = 2; k <= NDLY; k++) begin
            nega_ff[k] <= nega_ff[k-1];
            negb_ff[k] <= negb_ff[k-1];
         end
      end
   end

   prd_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (smvld_ff),
      .sum       (sum_ff),
      .mag       (smm_ff),
      .out_valid (nm_valid),
      .quo       (nm_q)
   );

   // output register: apply signs
   always_ff @(posedge clock) begin
      if (adv) begin
         dirx_ff <= nega_ff[NDLY] ? -prd_pkg::XY_OUT_BITS'(nm_q[0])
                                  :  prd_pkg::XY_OUT_BITS'(nm_q[0]);
         diry_ff <= negb_ff[NDLY] ? -prd_pkg::XY_OUT_BITS'(nm_q[1])
                                  :  prd_pkg::XY_OUT_BITS'(nm_q[1]);
         dirz_ff <= -nm_q[2];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         ivld_ff  <= 1'b0;
         shvld_ff <= 1'b0;
         sqvld_ff <= 1'b0;
         smvld_ff <= 1'b0;
         ovld_ff  <= 1'b0;
      end else if (adv) begin
         ivld_ff  <= req_tvalid;
         shvld_ff <= sc_valid;
         sqvld_ff <= shvld_ff;
         smvld_ff <= sqvld_ff;
         ovld_ff  <= nm_valid;
      end
   end

   assign rsp_tvalid = ovld_ff;
   assign rsp_tdata  = {3'b000, dirz_ff, diry_ff, dirx_ff};

endmodule
`default_nettype wire
